// ----- src/alids_pkg.sv -----
// ----------------------------------------------------------------------------
// alids_pkg
// Shared types and constants for the array list block: opcodes, status codes,
// controller states and the command and status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
package alids_pkg;

  // Field widths of the stream payloads
  localparam int OP_W  = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 7;
  localparam int IN_W  = 48;   // opcode, position, item_value, zero fill
  localparam int OUT_W = 48;   // status, found_position, read_value, element_count

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_WRITE_VAL,
    S_SCAN,
    S_READ_WAIT,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;     // latch the input transaction
    logic    dec_res;     // load result status, clear found and read data
    status_t res_status;  // status loaded by dec_res
    logic    rd_single;   // read the entry at position - 1
    logic    walk_init;   // set up the walk pointers for the current opcode
    logic    walk;        // advance the walk by one entry
    logic    walk_wr;     // write back each entry read by the walk
    logic    walk_dec;    // walk downward, write one above (insert shift)
    logic    wr_value;    // write item_value at position - 1
    logic    cnt_clr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_found;   // record the matching position, status ok
    logic    set_read;    // record the read data
    logic    load_out;    // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pos_ok_ins;  // 1 <= position <= count + 1
    logic            pos_ok_rd;   // 1 <= position <= count
    logic            full;
    logic            append;      // position == count + 1
    logic            tail;        // position == count
    logic            empty;
    logic            walk_done;
    logic            match;
    logic            out_free;
  } dp_stat_t;

endpackage

// ----- src/alids_ram.sv -----
// ----------------------------------------------------------------------------
// alids_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module alids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/alids_dpath.sv -----
// ----------------------------------------------------------------------------
// alids_dpath
// Datapath of the array list: entry RAM, entry count, walk pointers for
// shifting and searching, result registers and the output register.
// ----------------------------------------------------------------------------
module alids_dpath #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [alids_pkg::IN_W-1:0] s_tdata,
  input  alids_pkg::dp_cmd_t         cmd,
  output alids_pkg::dp_stat_t        stat,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic [alids_pkg::OUT_W-1:0] m_tdata
);

  import alids_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Captured transaction
  logic [OP_W-1:0]  op_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;

  // List state
  logic [CW-1:0] count;

  // Walk pointers
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] rd_last;
  logic          rd_more;
  logic          pend;
  logic [AW-1:0] pend_addr;

  // Result registers
  status_t          res_status;
  logic [POS_W-1:0] res_found;
  logic [VAL_W-1:0] res_read;

  // RAM ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [AW-1:0] p0;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] walk_waddr;
  logic [AW:0]   found_w;

  // Position checks against the count
  always_comb begin
    pos_x   = XW'(pos_q);
    cnt_x   = XW'(count);
    p0      = AW'(pos_x - XW'(1));
    cnt_m1  = count - CW'(1);
    found_w = (AW+1)'(pend_addr) + (AW+1)'(1);
    walk_waddr = cmd.walk_dec ? (pend_addr + AW'(1)) : (pend_addr - AW'(1));

    stat.op         = op_q;
    stat.pos_ok_ins = (pos_q != '0) && (pos_x <= cnt_x + XW'(1));
    stat.pos_ok_rd  = (pos_q != '0) && (pos_x <= cnt_x);
    stat.full       = (count == CW'(DEPTH));
    stat.append     = (pos_x == cnt_x + XW'(1));
    stat.tail       = (pos_x == cnt_x);
    stat.empty      = (count == '0);
    stat.walk_done  = !rd_more && !pend;
    stat.match      = pend && (ram_rdata == val_q);
    stat.out_free   = !m_tvalid || m_tready;
  end

  // Steer the RAM ports
  always_comb begin
    ram_re    = cmd.rd_single || (cmd.walk && rd_more);
    ram_raddr = cmd.rd_single ? p0 : rd_idx;
    ram_we    = cmd.wr_value || (cmd.walk && cmd.walk_wr && pend);
    ram_waddr = cmd.wr_value ? p0 : walk_waddr;
    ram_wdata = cmd.wr_value ? val_q : ram_rdata;
  end

  alids_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= s_tdata[OP_W-1:0];
      pos_q <= s_tdata[OP_W +: POS_W];
      val_q <= s_tdata[OP_W+POS_W +: VAL_W];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= cnt_m1;
    end
  end

  // Walk pointers: one read issued per cycle, the read entry lands in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_more <= 1'b0;
      pend    <= 1'b0;
    end else if (cmd.walk_init) begin
      rd_more <= 1'b1;
      pend    <= 1'b0;
      unique case (op_q)
        OP_INSERT: begin
          rd_idx  <= AW'(cnt_m1);
          rd_last <= p0;
        end
        OP_DELETE: begin
          rd_idx  <= AW'(pos_x);
          rd_last <= AW'(cnt_m1);
        end
        default: begin
          rd_idx  <= '0;
          rd_last <= AW'(cnt_m1);
        end
      endcase
    end else if (cmd.walk && rd_more) begin
      rd_idx    <= cmd.walk_dec ? (rd_idx - AW'(1)) : (rd_idx + AW'(1));
      rd_more   <= (rd_idx != rd_last);
      pend      <= 1'b1;
      pend_addr <= rd_idx;
    end else if (cmd.walk) begin
      pend <= 1'b0;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.dec_res) begin
      res_status <= cmd.res_status;
      res_found  <= '0;
      res_read   <= '0;
    end else if (cmd.set_found) begin
      res_status <= ST_OK;
      res_found  <= POS_W'(found_w);
    end else if (cmd.set_read) begin
      res_read <= ram_rdata;
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {CNT_W'(count), res_read, res_found, res_status};
    end
  end

endmodule

// ----- src/alids_ctrl.sv -----
// ----------------------------------------------------------------------------
// alids_ctrl
// Controller of the array list: decodes each operation, sequences the
// shift and search walks and hands the result to the output register.
// ----------------------------------------------------------------------------
module alids_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  alids_pkg::dp_stat_t stat,
  output alids_pkg::dp_cmd_t  cmd
);

  import alids_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;

    unique case (state)
      S_IDLE: begin
        s_tready    = !rst;
        cmd.capture = s_tvalid && !rst;
        if (s_tvalid && !rst) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        cmd.dec_res    = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_FINISH;
        unique case (stat.op)
          OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          OP_INSERT: begin
            priority if (!stat.pos_ok_ins) begin
              cmd.res_status = ST_BADPOS;
            end else if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else if (stat.append) begin
              state_next = S_WRITE_VAL;
            end else begin
              cmd.walk_init = 1'b1;
              state_next    = S_SHIFT_UP;
            end
          end
          OP_DELETE: begin
            priority if (!stat.pos_ok_rd) begin
              cmd.res_status = ST_BADPOS;
            end else if (stat.tail) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.walk_init = 1'b1;
              state_next    = S_SHIFT_DN;
            end
          end
          OP_SEARCH: begin
            cmd.res_status = ST_NOTFOUND;
            if (!stat.empty) begin
              cmd.walk_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          OP_READ: begin
            if (!stat.pos_ok_rd) begin
              cmd.res_status = ST_BADPOS;
            end else begin
              cmd.rd_single = 1'b1;
              state_next    = S_READ_WAIT;
            end
          end
          default: begin
            cmd.res_status = ST_OK;
          end
        endcase
      end

      // Move entries up from the tail down to the insert position
      S_SHIFT_UP: begin
        cmd.walk     = 1'b1;
        cmd.walk_wr  = 1'b1;
        cmd.walk_dec = 1'b1;
        if (stat.walk_done) begin
          state_next = S_WRITE_VAL;
        end
      end

      S_WRITE_VAL: begin
        cmd.wr_value = 1'b1;
        cmd.cnt_inc  = 1'b1;
        state_next   = S_FINISH;
      end

      // Move entries after the delete position down by one
      S_SHIFT_DN: begin
        cmd.walk    = 1'b1;
        cmd.walk_wr = 1'b1;
        if (stat.walk_done) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FINISH;
        end
      end

      // Compare entries in order, stop at the first match
      S_SCAN: begin
        cmd.walk = 1'b1;
        priority if (stat.match) begin
          cmd.set_found = 1'b1;
          state_next    = S_FINISH;
        end else if (stat.walk_done) begin
          state_next = S_FINISH;
        end
      end

      S_READ_WAIT: begin
        cmd.set_read = 1'b1;
        state_next   = S_FINISH;
      end

      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/array_list_insert_delete_search.sv -----
// Sequence: clear, rejected operations, ignored opcodes and delete of the last entry go
// from decode to the result; read passes through S_READ_WAIT and insert at the tail
// through S_WRITE_VAL; other inserts and deletes shift entries first, and search
// compares one entry per cycle up to the first match. Throughput: one operation at a time;
// the next is accepted in the cycle after the result is loaded; output stalls delay the load.
// Reset: synchronous rst clears the entry count and both handshakes; entries are not
// cleared, and no entry beyond the count is ever read out.
// ----------------------------------------------------------------------------
// array_list_insert_delete_search
// Ordered list of signed 32-bit values in a RAM of DEPTH entries with
// insert, delete, search, read and clear operations over stream channels.
// ----------------------------------------------------------------------------
module array_list_insert_delete_search #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // opcode[2:0], position[9:3], item_value[41:10], zero fill[47:42]
  input  logic [alids_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status[1:0], found_position[8:2], read_value[40:9], element_count[47:41]
  output logic [alids_pkg::OUT_W-1:0] m_tdata
);

  import alids_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  alids_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  alids_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- src/alids_checker.sv -----
// ----------------------------------------------------------------------------
// alids_checker
// Port-level checks for the array list block, bound to the top level.
// ----------------------------------------------------------------------------
module alids_checker #(
  parameter int DEPTH = 64
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [alids_pkg::IN_W-1:0]  s_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [alids_pkg::OUT_W-1:0] m_tdata
);

  import alids_pkg::*;

  logic [ST_W-1:0]  out_status;
  logic [POS_W-1:0] out_found;
  logic [VAL_W-1:0] out_read;
  logic [CNT_W-1:0] out_count;

  assign out_status  = m_tdata[ST_W-1:0];
  assign out_found   = m_tdata[ST_W +: POS_W];
  assign out_read    = m_tdata[ST_W+POS_W +: VAL_W];
  assign out_count   = m_tdata[ST_W+POS_W+VAL_W +: CNT_W];

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // One operation at a time: input closes after every transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an operation is in progress");

  // A waiting input transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
    else $error("input transaction changed while waiting");

  // A full report only comes with a list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_FULL) |-> (out_count == CNT_W'(DEPTH)))
    else $error("list full reported below capacity");

  // Failed operations return no data and no position
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != ST_OK) |-> (out_read == '0 && out_found == '0))
    else $error("failed operation returned data");

endmodule

bind array_list_insert_delete_search alids_checker #(
  .DEPTH (DEPTH)
) u_alids_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sv/tb_array_list_insert_delete_search.sv -----
// ----------------------------------------------------------------------------
// tb_array_list_insert_delete_search
// Stream-level test of the array list block. Each operation is sent on the
// slave channel, run through a behavioral copy of the list to get the reply
// it should produce, and each reply on the master channel is compared field
// by field in order. Directed checks on an empty and a short list come first.
// A fill-to-full and drain pass follows, then a long mix of random
// operations, with random idle bursts on both channels except at the very end.
// ----------------------------------------------------------------------------
module tb_array_list_insert_delete_search;
  import alids_pkg::*;

  localparam int DEPTH         = 64;
  localparam int STALL_LIMIT   = 1000;  // cycles with no transaction on either side
  localparam int SETTLE_CYCLES = 80;
  localparam int MAX_PRINTED   = 40;

  // Opcodes the block decodes as no-ops
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } list_cmd_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    status_t          status;
    logic [POS_W-1:0] found;
    logic [VAL_W-1:0] rd;
    logic [CNT_W-1:0] count;
  } list_reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  // Behavioral copy of the list
  logic [VAL_W-1:0]  shadow_list [DEPTH];
  int                shadow_len = 0;
  int                deepest_len = 0;

  list_reply_t       pending_replies [$];

  bit                idle_en = 1'b1;
  int                stall_pct = 0;
  int                window_left = 0;
  int                ready_hold = 0;
  int                quiet_cycles = 0;

  int                mismatch_count = 0;
  int                replies_checked = 0;
  int                ops_sent [8];
  int                badpos_seen = 0;
  int                full_seen = 0;
  int                notfound_seen = 0;

  array_list_insert_delete_search #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one operation to the shadow list and return the reply it earns
  function automatic list_reply_t apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                logic [VAL_W-1:0] val);
    list_reply_t r;
    int p;
    int i;
    p = int'(pos);
    r.op = op;
    r.status = ST_OK;
    r.found = '0;
    r.rd = '0;
    case (op)
      OP_CLEAR: begin
        shadow_len = 0;
      end
      OP_INSERT: begin
        if (p < 1 || p > shadow_len + 1) begin
          r.status = ST_BADPOS;
        end else if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i >= p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p-1] = val;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      OP_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == val) begin
            r.found = POS_W'(i + 1);
            r.status = ST_OK;
            break;
          end
        end
      end
      OP_READ: begin
        if (p < 1 || p > shadow_len) r.status = ST_BADPOS;
        else r.rd = shadow_list[p-1];
      end
      default: ;
    endcase
    if (shadow_len > deepest_len) deepest_len = shadow_len;
    r.count = CNT_W'(shadow_len);
    return r;
  endfunction

  // Draw a value that often repeats, so searches hit and find first matches
  function automatic logic [VAL_W-1:0] draw_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = VAL_W'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = VAL_NEG1;
          default: v = '0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Pick a random operation, mostly with a legal position for the current length
  function automatic list_cmd_t draw_list_cmd();
    list_cmd_t c;
    int r;
    int ins_pct;
    r = $urandom_range(0, 99);
    ins_pct = (shadow_len < 8) ? 55 : (shadow_len > 56) ? 25 : 38;
    if (r < 2) begin
      c.op = OP_CLEAR;
    end else if (r < 4) begin
      c.op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    end else if (r < 4 + ins_pct) begin
      c.op = OP_INSERT;
    end else begin
      case ($urandom_range(0, 2))
        0: c.op = OP_DELETE;
        1: c.op = OP_SEARCH;
        default: c.op = OP_READ;
      endcase
    end
    if ($urandom_range(0, 9) == 0 || c.op == OP_CLEAR || c.op == OP_SEARCH) begin
      c.pos = POS_W'($urandom_range(0, 127));
    end else if (c.op == OP_INSERT) begin
      c.pos = POS_W'($urandom_range(1, shadow_len + 1));
    end else begin
      c.pos = (shadow_len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, shadow_len));
    end
    if (c.op == OP_SEARCH && shadow_len > 0 && $urandom_range(0, 9) < 7) begin
      c.val = shadow_list[$urandom_range(0, shadow_len - 1)];
    end else begin
      c.val = draw_value();
    end
    return c;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(string what, logic [OP_W-1:0] op, logic [VAL_W-1:0] want_v,
                                 logic [VAL_W-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("MISMATCH reply %0d op %0d %s: expected %0h got %0h",
               replies_checked, op, what, want_v, got_v);
  endtask

  // Send one operation; valid stays high unless an idle burst comes first
  task automatic send_list_cmd(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] val);
    int gap;
    list_reply_t want;
    if (idle_en && $urandom_range(0, 99) < stall_pct) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({val, pos, op});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = apply_list_op(op, pos, val);
    pending_replies.push_back(want);
    ops_sent[op]++;
    case (want.status)
      ST_BADPOS: badpos_seen++;
      ST_FULL: full_seen++;
      ST_NOTFOUND: notfound_seen++;
      default: ;
    endcase
  endtask

  task automatic send_random_cmds(int n);
    list_cmd_t c;
    repeat (n) begin
      c = draw_list_cmd();
      send_list_cmd(c.op, c.pos, c.val);
    end
  endtask

  // Rejected positions, empty search and ignored opcodes on an empty list, then a clear
  task automatic test_empty_list();
    send_list_cmd(OP_SEARCH, 0, '0);
    send_list_cmd(OP_READ, 1, '0);
    send_list_cmd(OP_READ, 0, '0);
    send_list_cmd(OP_DELETE, 1, '0);
    send_list_cmd(OP_INSERT, 0, VAL_MAX);
    send_list_cmd(OP_INSERT, 2, VAL_MIN);
    send_list_cmd(OP_RSVD_LO, 127, VAL_MIN);
    send_list_cmd(OP_RSVD_MID, 64, VAL_NEG1);
    send_list_cmd(OP_RSVD_HI, 127, VAL_MAX);
    send_list_cmd(OP_CLEAR, 0, '0);
  endtask

  // Insert at head, middle and tail, duplicates, search, read and delete
  task automatic test_edit_ops();
    send_list_cmd(OP_INSERT, 1, VAL_MAX);
    send_list_cmd(OP_INSERT, 2, VAL_MIN);
    send_list_cmd(OP_INSERT, 1, VAL_NEG1);
    send_list_cmd(OP_INSERT, 2, '0);
    send_list_cmd(OP_INSERT, 3, VAL_MIN);
    send_list_cmd(OP_SEARCH, 127, VAL_MIN);
    send_list_cmd(OP_SEARCH, 0, 32'd12345);
    send_list_cmd(OP_READ, 1, '0);
    send_list_cmd(OP_READ, 5, '0);
    send_list_cmd(OP_READ, 6, '0);
    send_list_cmd(OP_DELETE, 1, '0);
    send_list_cmd(OP_DELETE, 4, '0);
    send_list_cmd(OP_DELETE, 2, '0);
    send_list_cmd(OP_INSERT, 127, VAL_MAX);
    send_list_cmd(OP_CLEAR, 0, '0);
  endtask

  // Grow the list to DEPTH, hit the full cases, then drain it to empty
  task automatic test_fill_and_drain();
    int r;
    send_list_cmd(OP_CLEAR, 0, '0);
    while (shadow_len < DEPTH)
      send_list_cmd(OP_INSERT, POS_W'($urandom_range(1, shadow_len + 1)), draw_value());
    send_list_cmd(OP_INSERT, POS_W'(DEPTH + 1), VAL_MAX);
    send_list_cmd(OP_INSERT, 1, VAL_MIN);
    send_list_cmd(OP_INSERT, POS_W'(DEPTH + 2), '0);
    send_list_cmd(OP_READ, POS_W'(DEPTH), '0);
    send_list_cmd(OP_SEARCH, 0, shadow_list[DEPTH-1]);
    send_list_cmd(OP_DELETE, POS_W'(DEPTH), '0);
    send_list_cmd(OP_INSERT, POS_W'(DEPTH), VAL_NEG1);
    send_list_cmd(OP_INSERT, POS_W'(DEPTH), VAL_NEG1);
    while (shadow_len > 0) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        send_list_cmd(OP_DELETE, POS_W'($urandom_range(1, shadow_len)), '0);
      end else if (r == 8) begin
        send_list_cmd(OP_READ, POS_W'($urandom_range(1, shadow_len)), '0);
      end else begin
        send_list_cmd(OP_SEARCH, 0, shadow_list[$urandom_range(0, shadow_len - 1)]);
      end
    end
  endtask

  task automatic test_random_mix();
    send_random_cmds(420);
  endtask

  // Back-to-back traffic with both channels always ready
  task automatic test_unstalled_tail();
    idle_en = 1'b0;
    send_random_cmds(100);
  endtask

  // Drive ready low in random bursts; re-pick the burst rate per window
  always @(posedge clk) begin
    if (window_left == 0) begin
      window_left <= $urandom_range(32, 96);
      case ($urandom_range(0, 2))
        0: stall_pct <= 0;
        1: stall_pct <= 10;
        default: stall_pct <= 30;
      endcase
    end else begin
      window_left <= window_left - 1;
    end
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 99) < stall_pct) begin
      ready_hold <= $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each reply with the oldest pending one
  always @(posedge clk) begin : check_replies
    list_reply_t want;
    list_reply_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tdata[ST_W-1:0]);
      got.found = m_tdata[ST_W +: POS_W];
      got.rd = m_tdata[ST_W+POS_W +: VAL_W];
      got.count = m_tdata[ST_W+POS_W+VAL_W +: CNT_W];
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with nothing pending", '0, '0, VAL_W'(m_tdata));
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", want.op, VAL_W'(want.status), VAL_W'(got.status));
        if (got.found !== want.found)
          report_mismatch("found_position", want.op, VAL_W'(want.found), VAL_W'(got.found));
        if (got.rd !== want.rd)
          report_mismatch("read_value", want.op, want.rd, got.rd);
        if (got.count !== want.count)
          report_mismatch("element_count", want.op, VAL_W'(want.count), VAL_W'(got.count));
      end
      replies_checked++;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("array_list_insert_delete_search verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_edit_ops();
    test_fill_and_drain();
    test_random_mix();
    test_unstalled_tail();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran clear %0d, insert %0d, delete %0d, search %0d, read %0d, no-op %0d; %0d replies",
             ops_sent[OP_CLEAR], ops_sent[OP_INSERT], ops_sent[OP_DELETE],
             ops_sent[OP_SEARCH], ops_sent[OP_READ],
             ops_sent[OP_RSVD_LO] + ops_sent[OP_RSVD_MID] + ops_sent[OP_RSVD_HI],
             replies_checked);
    $display("bad positions %0d, inserts on full list %0d, failed searches %0d, deepest %0d/%0d",
             badpos_seen, full_seen, notfound_seen, deepest_len, DEPTH);
    if (mismatch_count == 0) begin
      $display("array_list_insert_delete_search verification clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("array_list_insert_delete_search verification failed");
    end
    $finish;
  end

endmodule
